/* rtl/mcsfs_pkg.sv */
package mcsfs_pkg;

    localparam int unsigned RegW = 32;
    localparam int unsigned IdxW = 1;
    localparam int unsigned QDepth = 2;

    localparam logic [IdxW-1:0] CFG_TICKS = 1'b0;
    localparam logic [IdxW-1:0] CFG_DELAY = 1'b1;

    localparam logic [31:0] T_MHDR = 32'h4D484452;
    localparam logic [31:0] T_FRAM = 32'h4652414D;
    localparam logic [31:0] T_IHDR = 32'h49484452;
    localparam logic [31:0] T_IEND = 32'h49454E44;

    localparam logic [31:0] MhdrMinLen = 32'd28;
    localparam logic [31:0] TicksReset = 32'd1000;
    localparam logic [31:0] DelayReset = 32'd100;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIG   = 3'd1;
    localparam logic [2:0] ST_TRUNC     = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_OPEN      = 3'd4;
    localparam logic [2:0] ST_NO_FRAMES = 3'd5;

    typedef enum logic [2:0] {
        PH_SIG, PH_HDR, PH_DATA, PH_CRC, PH_ERR
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE, BK_EMIT, BK_DIV
    } t_back_state;

    function automatic logic [7:0] mng_sig(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = 8'h8a;
            3'd1: r = 8'h4d;
            3'd2: r = 8'h4e;
            3'd3: r = 8'h47;
            3'd4: r = 8'h0d;
            3'd5: r = 8'h0a;
            3'd6: r = 8'h1a;
            default: r = 8'h0a;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] png_sig(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = 8'h89;
            3'd1: r = 8'h50;
            3'd2: r = 8'h4e;
            3'd3: r = 8'h47;
            3'd4: r = 8'h0d;
            3'd5: r = 8'h0a;
            3'd6: r = 8'h1a;
            default: r = 8'h0a;
        endcase
        return r;
    endfunction

    // Work command handed from the parser to the emitter.
    typedef struct packed {
        logic        sig;       // emit the PNG signature first
        logic        hdr;       // emit the 8 header bytes
        logic        byte_en;   // emit one copied byte
        logic [7:0]  data;
        logic [63:0] header;
        logic        frame_end;
        logic        use_pend;  // delay needs the divider
        logic [31:0] delay;     // pending delay or default
        logic [31:0] ticks;
        logic        stat;
        logic [2:0]  status;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] tps;
        logic [31:0] frames;
    } t_cmd;

endpackage

/* rtl/mcsfs_if.sv */
interface mcsfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, in_byte, in_last, input ready);
    modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface mcsfs_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic [31:0] delay_ms;
    logic [2:0]  status;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [31:0] ticks_per_second;
    logic [31:0] frame_count;
    logic        run_last;
    modport source (output valid, kind, out_byte, frame_end, delay_ms, status, image_width,
        image_height, ticks_per_second, frame_count, run_last, input ready);
    modport sink (input valid, kind, out_byte, frame_end, delay_ms, status, image_width,
        image_height, ticks_per_second, frame_count, run_last, output ready);
endinterface

/* rtl/mcsfs_parser.sv */
module mcsfs_parser
    import mcsfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [31:0] i_def_ticks,
    input  logic [31:0] i_def_delay,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_len, n_len;
    logic [63:0] r_hdr, n_hdr;
    logic        r_png, n_png;
    logic [31:0] r_msh, n_msh;
    logic [31:0] r_w, n_w, r_h, n_h, r_t, n_t;
    logic [2:0]  r_fsub, n_fsub;
    logic [1:0]  r_fcnt, n_fcnt;
    logic        r_pv, n_pv;
    logic [31:0] r_pval, n_pval;
    logic [31:0] r_frames, n_frames;
    logic [2:0]  r_err, n_err;
    logic        r_short, n_short;

    t_phase      ph;
    logic [31:0] cnt, len, t, msh, w, h, tk, pval, frames;
    logic [63:0] hdr, hsh;
    logic        png, pv, shrt;
    logic [2:0]  fsub, err, st;
    logic [1:0]  fcnt;
    logic [31:0] cnt1;
    logic        go;
    t_cmd        cmd;
    logic        emit;

    assign o_ready = i_cmd_ready;
    assign go      = i_valid && i_cmd_ready;

    always_comb begin
        logic fresh;
        fresh  = (r_phase == PH_SIG) && (r_cnt == '0);
        ph     = r_phase;
        cnt    = r_cnt;
        len    = fresh ? '0 : r_len;
        hdr    = fresh ? '0 : r_hdr;
        png    = fresh ? 1'b0 : r_png;
        msh    = fresh ? '0 : r_msh;
        w      = fresh ? '0 : r_w;
        h      = fresh ? '0 : r_h;
        tk     = fresh ? i_def_ticks : r_t;
        fsub   = fresh ? '0 : r_fsub;
        fcnt   = fresh ? '0 : r_fcnt;
        pv     = fresh ? 1'b0 : r_pv;
        pval   = fresh ? '0 : r_pval;
        frames = fresh ? '0 : r_frames;
        err    = fresh ? '0 : r_err;
        shrt   = fresh ? 1'b0 : r_short;
        t      = hdr[31:0];
        cmd    = '0;
        emit   = 1'b0;
        cnt1   = cnt + 32'd1;
        hsh    = {hdr[55:0], i_byte};
        st     = ST_OK;
        unique case (ph)
            PH_SIG: begin
                if (i_byte != mng_sig(cnt[2:0])) begin
                    err = ST_BAD_SIG;
                    ph  = PH_ERR;
                end else if (cnt1 == 32'd8) begin
                    ph  = PH_HDR;
                    cnt = '0;
                end else begin
                    cnt = cnt1;
                end
            end
            PH_HDR: begin
                hdr = hsh;
                if (cnt1 < 32'd8) begin
                    cnt = cnt1;
                end else begin
                    len  = hsh[63:32];
                    t    = hsh[31:0];
                    fsub = '0;
                    fcnt = '0;
                    msh  = '0;
                    shrt = (t == T_MHDR) && (len < MhdrMinLen);
                    if (!png && t == T_IHDR) begin
                        cmd.sig = 1'b1;
                        png     = 1'b1;
                    end
                    cmd.hdr    = png;
                    cmd.header = hsh;
                    emit       = png;
                    cnt        = '0;
                    ph         = PH_DATA;
                    if (len == '0) begin
                        if (t == T_FRAM) pv = (fsub == 3'd5);
                        ph = PH_CRC;
                    end
                end
            end
            PH_DATA: begin
                cmd.byte_en = png;
                cmd.data    = i_byte;
                emit        = png;
                if (t == T_FRAM) begin
                    unique case (fsub)
                        3'd0: fsub = 3'd1;
                        3'd1: if (i_byte == 8'd0) fsub = 3'd2;
                        3'd2: begin
                            fsub = (i_byte != 8'd0) ? 3'd3 : 3'd6;
                            fcnt = '0;
                        end
                        3'd3: begin
                            if (fcnt == 2'd2) begin
                                fsub = 3'd4;
                                fcnt = '0;
                            end else begin
                                fcnt = fcnt + 2'd1;
                            end
                        end
                        3'd4: begin
                            pval = {pval[23:0], i_byte};
                            if (fcnt == 2'd3) fsub = 3'd5;
                            else fcnt = fcnt + 2'd1;
                        end
                        default: ;
                    endcase
                end
                if (t == T_MHDR && !shrt && cnt < 32'd12) begin
                    msh = {msh[23:0], i_byte};
                    if (cnt == 32'd3) w = msh;
                    else if (cnt == 32'd7) h = msh;
                    else if (cnt == 32'd11 && msh != '0) tk = msh;
                end
                cnt = cnt1;
                if (cnt1 == len) begin
                    if (t == T_FRAM) pv = (fsub == 3'd5);
                    ph  = PH_CRC;
                    cnt = '0;
                end
            end
            PH_CRC: begin
                cnt = cnt1;
                cmd.data = i_byte;
                if (cnt1 == 32'd4 && shrt) begin
                    cmd.byte_en = png;
                    emit        = png;
                    err         = ST_SHORT;
                    ph          = PH_ERR;
                end else begin
                    cmd.byte_en = png;
                    emit        = png;
                    if (cnt1 == 32'd4 && png && t == T_IEND) begin
                        cmd.frame_end = 1'b1;
                        cmd.use_pend  = pv;
                        cmd.delay     = pv ? pval : i_def_delay;
                        cmd.ticks     = tk;
                        frames        = frames + 32'd1;
                        pv            = 1'b0;
                        png           = 1'b0;
                    end
                    if (cnt1 == 32'd4) begin
                        ph  = PH_HDR;
                        cnt = '0;
                        hdr = '0;
                    end
                end
            end
            default: ;
        endcase
        if (i_last) begin
            if (err != ST_OK) st = err;
            else if (ph == PH_SIG) st = ST_BAD_SIG;
            else if (ph != PH_HDR || cnt != '0) st = ST_TRUNC;
            else if (png) st = ST_OPEN;
            else if (frames == '0) st = ST_NO_FRAMES;
            else st = ST_OK;
            cmd.stat   = 1'b1;
            cmd.status = st;
            cmd.width  = w;
            cmd.height = h;
            cmd.tps    = tk;
            cmd.frames = frames;
            emit       = 1'b1;
            ph         = PH_SIG;
            cnt        = '0;
        end
        n_phase = ph; n_cnt = cnt; n_len = len; n_hdr = hdr; n_png = png; n_msh = msh;
        n_w = w; n_h = h; n_t = tk; n_fsub = fsub; n_fcnt = fcnt; n_pv = pv;
        n_pval = pval; n_frames = frames; n_err = err; n_short = shrt;
    end

    assign o_cmd_valid = i_valid && emit;
    assign o_cmd       = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIG;
            r_cnt   <= '0;
        end else if (go) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
        if (go) begin
            r_len <= n_len; r_hdr <= n_hdr; r_png <= n_png; r_msh <= n_msh;
            r_w <= n_w; r_h <= n_h; r_t <= n_t; r_fsub <= n_fsub; r_fcnt <= n_fcnt;
            r_pv <= n_pv; r_pval <= n_pval; r_frames <= n_frames; r_err <= n_err;
            r_short <= n_short;
        end
    end

endmodule

/* rtl/mcsfs_fifo.sv */
module mcsfs_fifo
    import mcsfs_pkg::*;
#(
    parameter int unsigned Depth = QDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_data
);

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    t_cmd             r_mem [Depth];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             wr, rd;

    assign o_ready = (r_cnt < (AW+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule

/* rtl/mcsfs_emitter.sv */
module mcsfs_emitter
    import mcsfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    mcsfs_out_if.source out_ch
);

    t_back_state  r_st, n_st;
    t_cmd         r_cmd;
    logic [4:0]   r_idx, n_idx;
    logic [4:0]   r_total;
    // Restoring divider: 43-bit numerator, 33-bit divisor.
    logic [42:0]  r_num;
    logic [33:0]  r_rem;
    logic [32:0]  r_den;
    logic [5:0]   r_dcnt;
    logic [42:0]  r_q;
    logic [31:0]  r_dly;
    logic [42:0]  num0;
    logic [32:0]  t1;
    logic [33:0]  trial;
    logic         out_go;
    logic         load;
    logic [4:0]   total;

    assign out_go = out_ch.valid && out_ch.ready;
    assign t1 = (i_cmd.ticks == '0) ? 33'd1 : {1'b0, i_cmd.ticks};
    // 2000*delay + ticks fits in 43 bits.
    assign num0 = ({11'd0, i_cmd.delay} * 43'd2000) + {10'd0, t1};
    assign trial = {r_rem[32:0], r_num[42]} - {1'b0, r_den};
    assign total = (i_cmd.sig ? 5'd8 : 5'd0) + (i_cmd.hdr ? 5'd8 : 5'd0)
                 + (i_cmd.byte_en ? 5'd1 : 5'd0) + (i_cmd.stat ? 5'd1 : 5'd0);

    always_comb begin
        n_st    = r_st;
        n_idx   = r_idx;
        load    = 1'b0;
        o_ready = 1'b0;
        unique case (r_st)
            BK_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    load  = 1'b1;
                    n_idx = '0;
                    n_st  = (i_cmd.frame_end && i_cmd.use_pend) ? BK_DIV : BK_EMIT;
                end
            end
            BK_DIV: if (r_dcnt == 6'd43) n_st = BK_EMIT;
            BK_EMIT: begin
                if (out_go) begin
                    n_idx = r_idx + 5'd1;
                    if (r_idx + 5'd1 == r_total) n_st = BK_IDLE;
                end
            end
            default: n_st = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_IDLE;
            r_idx <= '0;
        end else begin
            r_st <= n_st;
            r_idx <= n_idx;
        end
        if (load) begin
            r_cmd   <= i_cmd;
            r_total <= total;
            r_num   <= num0;
            r_rem   <= '0;
            r_den   <= {t1[31:0], 1'b0};
            r_dcnt  <= '0;
            r_q     <= '0;
            r_dly   <= i_cmd.delay;
        end else if (r_st == BK_DIV) begin
            if (r_dcnt != 6'd43) begin
                r_num  <= {r_num[41:0], 1'b0};
                r_dcnt <= r_dcnt + 6'd1;
                if (!trial[33]) begin
                    r_rem <= trial;
                    r_q   <= {r_q[41:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[32:0], r_num[42]};
                    r_q   <= {r_q[41:0], 1'b0};
                end
            end else begin
                r_dly <= (r_q[42:32] != '0) ? 32'hFFFF_FFFF : r_q[31:0];
            end
        end
    end

    always_comb begin
        logic [4:0] k;
        logic [4:0] off;
        logic [4:0] hb;
        k   = r_idx;
        off = r_cmd.sig ? 5'd8 : 5'd0;
        hb  = r_cmd.hdr ? 5'd8 : 5'd0;
        out_ch.valid            = (r_st == BK_EMIT);
        out_ch.kind             = 1'b0;
        out_ch.out_byte         = '0;
        out_ch.frame_end        = 1'b0;
        out_ch.delay_ms         = '0;
        out_ch.status           = ST_OK;
        out_ch.image_width      = '0;
        out_ch.image_height     = '0;
        out_ch.ticks_per_second = '0;
        out_ch.frame_count      = '0;
        out_ch.run_last         = (r_idx + 5'd1 == r_total);
        if (r_cmd.sig && k < 5'd8) begin
            out_ch.out_byte = png_sig(k[2:0]);
        end else if (r_cmd.hdr && k < off + 5'd8) begin
            out_ch.out_byte = r_cmd.header[8*(7 - (k - off)) +: 8];
        end else if (r_cmd.byte_en && k == off + hb) begin
            out_ch.out_byte  = r_cmd.data;
            out_ch.frame_end = r_cmd.frame_end;
            out_ch.delay_ms  = r_cmd.frame_end ? r_dly : '0;
        end else begin
            out_ch.kind             = 1'b1;
            out_ch.status           = r_cmd.status;
            out_ch.image_width      = r_cmd.width;
            out_ch.image_height     = r_cmd.height;
            out_ch.ticks_per_second = r_cmd.tps;
            out_ch.frame_count      = r_cmd.frames;
        end
    end

endmodule

/* rtl/mng_chunk_stream_frame_splitter_core.sv */
// MNG frame splitter. Bytes of an MNG file enter on in_ch, one per beat, with
// in_last on the final byte. Each PNG frame found (IHDR through IEND) leaves on
// out_ch as a PNG signature followed by every chunk byte; the last IEND byte has
// frame_end and delay_ms. The final byte of a file adds a status beat
// (kind = 1). run_last marks the last result beat caused by one input beat.
// The parser takes one byte per cycle while the queue has room and writes one
// command per byte that produces output into a two-entry queue. The emitter
// replays each command as 1 to 17 beats, one beat per cycle while the receiver
// is ready. A frame end with a pending FRAM delay adds a serial divide in the
// emitter. Sustained rate is set by the emitter: it returns to idle after the
// last beat of each command before it takes the next one from the queue.
// Reset clears the parser to the signature phase, empties the queue and loads
// the configuration registers with 1000 ticks/s and 100 ms. When the receiver
// deasserts ready, the emitter holds its beat, the queue fills and the parser
// stops accepting bytes.
module mng_chunk_stream_frame_splitter_core
    import mcsfs_pkg::*;
#(
    parameter int unsigned QueueDepth = QDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mcsfs_in_if.sink        in_ch,
    mcsfs_out_if.source     out_ch,
    input  logic            i_cfg_we,
    input  logic [IdxW-1:0] i_cfg_idx,
    input  logic [RegW-1:0] i_cfg_data
);

    logic [31:0] r_def_ticks, r_def_delay;
    logic        p_valid, p_ready, q_valid, q_ready;
    t_cmd        p_cmd, q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_ticks <= TicksReset;
            r_def_delay <= DelayReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICKS: r_def_ticks <= i_cfg_data;
                CFG_DELAY: r_def_delay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mcsfs_parser u_parser (
        .i_clk, .i_rst_n,
        .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_byte(in_ch.in_byte), .i_last(in_ch.in_last),
        .i_def_ticks(r_def_ticks), .i_def_delay(r_def_delay),
        .o_cmd_valid(p_valid), .i_cmd_ready(p_ready), .o_cmd(p_cmd)
    );

    mcsfs_fifo #(.Depth(QueueDepth)) u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(p_valid), .o_ready(p_ready), .i_data(p_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_cmd)
    );

    mcsfs_emitter u_emit (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .out_ch(out_ch)
    );

    // A frame end on the final byte of a file is followed by the status beat.
    a_fe_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.frame_end |-> !out_ch.kind)
        else $error("frame end on a status beat");
    a_stat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.kind |-> out_ch.run_last)
        else $error("status beat not last");
    a_stall_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_valid && !p_ready |-> !in_ch.ready || !in_ch.valid)
        else $error("input accepted while queue full");

endmodule

/* test/mcsfs_checker.sv */
module mcsfs_checker
    import mcsfs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    mcsfs_in_if             in_ch,
    mcsfs_out_if            out_ch,
    input  logic            i_cfg_we,
    input  logic [IdxW-1:0] i_cfg_idx,
    input  logic [RegW-1:0] i_cfg_data,
    output int              o_errors,
    output int              o_pending,
    output int              o_frames,
    output int              o_files
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MngSig = 64'h8a4d4e470d0a1a0a;
    localparam logic [63:0] PngSig = 64'h89504e470d0a1a0a;

    // Progress through a FRAM body.
    localparam logic [2:0] FS_MODE    = 3'd0;
    localparam logic [2:0] FS_NAME    = 3'd1;
    localparam logic [2:0] FS_FLAG    = 3'd2;
    localparam logic [2:0] FS_SKIP    = 3'd3;
    localparam logic [2:0] FS_DELAY   = 3'd4;
    localparam logic [2:0] FS_DONE    = 3'd5;
    localparam logic [2:0] FS_NODELAY = 3'd6;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic        fe;
        logic [31:0] dly;
        logic [2:0]  st;
        logic [31:0] wid;
        logic [31:0] hgt;
        logic [31:0] tps;
        logic [31:0] fc;
        logic        rl;
    } t_result_beat;

    t_result_beat frame_beats_q[$];
    t_result_beat step_beats[$];

    logic [31:0] cfg_ticks, cfg_delay;
    t_phase      phase;
    logic [31:0] cnt, dlen;
    logic [63:0] hdr;
    logic        in_frame, mshort, dly_ok;
    logic [31:0] mshift, wid, hgt, tps, dly_val, nframes;
    logic [2:0]  fsub, err;
    int unsigned fcnt;

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_frames = 0;
        o_files = 0;
    end

    task automatic new_file();
        phase = PH_SIG;
        cnt = '0;
        dlen = '0;
        hdr = '0;
        in_frame = 1'b0;
        mshift = '0;
        wid = '0;
        hgt = '0;
        tps = cfg_ticks;
        fsub = FS_MODE;
        fcnt = 0;
        dly_ok = 1'b0;
        dly_val = '0;
        nframes = '0;
        err = ST_OK;
        mshort = 1'b0;
    endtask

    task automatic add(input logic kind, input logic [7:0] b, input logic fe,
                       input logic [31:0] d, input logic [2:0] st);
        t_result_beat r;
        r = '0;
        r.kind = kind;
        r.data = b;
        r.fe = fe;
        r.dly = d;
        r.st = st;
        if (kind) begin
            r.wid = wid;
            r.hgt = hgt;
            r.tps = tps;
            r.fc = nframes;
        end
        step_beats.insert(step_beats.size(), r);
    endtask

    function automatic logic [31:0] frame_delay();
        logic [63:0] t, q;
        if (!dly_ok) return cfg_delay;
        t = (tps != 0) ? {32'd0, tps} : 64'd1;
        q = (64'd2000 * {32'd0, dly_val} + t) / (64'd2 * t);
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    task automatic body_done(input logic [31:0] typ);
        if (typ == T_FRAM) dly_ok = (fsub == FS_DONE);
        phase = PH_CRC;
        cnt = '0;
    endtask

    task automatic fram_step(input logic [7:0] b);
        case (fsub)
            FS_MODE: fsub = FS_NAME;
            FS_NAME: if (b == 8'd0) fsub = FS_FLAG;
            FS_FLAG: begin
                fsub = (b != 0) ? FS_SKIP : FS_NODELAY;
                fcnt = 0;
            end
            FS_SKIP: begin
                fcnt++;
                if (fcnt == 3) begin
                    fsub = FS_DELAY;
                    fcnt = 0;
                end
            end
            FS_DELAY: begin
                dly_val = {dly_val[23:0], b};
                fcnt++;
                if (fcnt == 4) fsub = FS_DONE;
            end
            default: ;
        endcase
    endtask

    task automatic predict(input logic [7:0] b, input logic last);
        logic [31:0] typ;
        logic [2:0]  st;
        typ = hdr[31:0];
        step_beats = {};
        if (phase == PH_SIG && cnt == 0) new_file();
        case (phase)
            PH_SIG: begin
                if (b != MngSig[63 - 8 * cnt[2:0] -: 8]) begin
                    err = ST_BAD_SIG;
                    phase = PH_ERR;
                end else begin
                    cnt++;
                    if (cnt == 8) begin
                        phase = PH_HDR;
                        cnt = '0;
                    end
                end
            end
            PH_HDR: begin
                hdr = {hdr[55:0], b};
                cnt++;
                if (cnt == 8) begin
                    dlen = hdr[63:32];
                    typ = hdr[31:0];
                    fsub = FS_MODE;
                    fcnt = 0;
                    mshift = '0;
                    mshort = (typ == T_MHDR) && (dlen < MhdrMinLen);
                    if (!in_frame && typ == T_IHDR) begin
                        for (int k = 0; k < 8; k++)
                            add(1'b0, PngSig[63 - 8 * k -: 8], 1'b0, 32'd0, ST_OK);
                        in_frame = 1'b1;
                    end
                    if (in_frame)
                        for (int k = 7; k >= 0; k--)
                            add(1'b0, hdr[8 * k +: 8], 1'b0, 32'd0, ST_OK);
                    cnt = '0;
                    phase = PH_DATA;
                    if (dlen == 0) body_done(typ);
                end
            end
            PH_DATA: begin
                if (in_frame) add(1'b0, b, 1'b0, 32'd0, ST_OK);
                if (typ == T_FRAM) fram_step(b);
                if (typ == T_MHDR && !mshort && cnt < 12) begin
                    mshift = {mshift[23:0], b};
                    if (cnt == 3) wid = mshift;
                    else if (cnt == 7) hgt = mshift;
                    else if (cnt == 11 && mshift != 0) tps = mshift;
                end
                cnt++;
                if (cnt == dlen) body_done(typ);
            end
            PH_CRC: begin
                cnt++;
                if (cnt == 4 && mshort) begin
                    if (in_frame) add(1'b0, b, 1'b0, 32'd0, ST_OK);
                    err = ST_SHORT;
                    phase = PH_ERR;
                end else begin
                    if (cnt == 4 && in_frame && typ == T_IEND) begin
                        add(1'b0, b, 1'b1, frame_delay(), ST_OK);
                        nframes++;
                        dly_ok = 1'b0;
                        in_frame = 1'b0;
                    end else if (in_frame) begin
                        add(1'b0, b, 1'b0, 32'd0, ST_OK);
                    end
                    if (cnt == 4) begin
                        phase = PH_HDR;
                        cnt = '0;
                        hdr = '0;
                    end
                end
            end
            default: ;
        endcase

        if (last) begin
            if (err != ST_OK) st = err;
            else if (phase == PH_SIG) st = ST_BAD_SIG;
            else if (phase != PH_HDR || cnt != 0) st = ST_TRUNC;
            else if (in_frame) st = ST_OPEN;
            else if (nframes == 0) st = ST_NO_FRAMES;
            else st = ST_OK;
            add(1'b1, 8'd0, 1'b0, 32'd0, st);
            phase = PH_SIG;
            cnt = '0;
        end

        if (step_beats.size() > 0) step_beats[step_beats.size() - 1].rl = 1'b1;
        foreach (step_beats[i]) frame_beats_q.insert(frame_beats_q.size(), step_beats[i]);
    endtask

    always @(posedge i_clk) begin
        t_result_beat got, want;
        if (!i_rst_n) begin
            cfg_ticks = TicksReset;
            cfg_delay = DelayReset;
            new_file();
            frame_beats_q = {};
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TICKS) cfg_ticks = i_cfg_data;
                else if (i_cfg_idx == CFG_DELAY) cfg_delay = i_cfg_data;
            end
            if (in_ch.valid && in_ch.ready) predict(in_ch.in_byte, in_ch.in_last);
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.kind, out_ch.out_byte, out_ch.frame_end, out_ch.delay_ms,
                       out_ch.status, out_ch.image_width, out_ch.image_height,
                       out_ch.ticks_per_second, out_ch.frame_count, out_ch.run_last};
                if (got.fe) o_frames++;
                if (got.kind) o_files++;
                if (frame_beats_q.size() == 0) begin
                    $display("%0t: unexpected beat kind=%0d byte=%h status=%0d", $realtime,
                             got.kind, got.data, got.st);
                    o_errors++;
                end else begin
                    want = frame_beats_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected kind=%0d byte=%h end=%0d dly=%0d st=%0d",
                                 $realtime, want.kind, want.data, want.fe, want.dly, want.st);
                        $display("    w=%0d h=%0d tps=%0d frames=%0d last=%0d", want.wid,
                                 want.hgt, want.tps, want.fc, want.rl);
                        $display("    actual kind=%0d byte=%h end=%0d dly=%0d st=%0d", got.kind,
                                 got.data, got.fe, got.dly, got.st);
                        $display("    w=%0d h=%0d tps=%0d frames=%0d last=%0d", got.wid,
                                 got.hgt, got.tps, got.fc, got.rl);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = frame_beats_q.size();
    end

endmodule

/* test/tb.sv */
module tb;
    import mcsfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MngSig = 64'h8a4d4e470d0a1a0a;
    localparam logic [31:0] T_IDAT = 32'h49444154;
    localparam logic [31:0] T_TERM = 32'h5445524D;
    localparam int          CycleLimit = 400000;
    localparam int          SettleCycles = 80;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [IdxW-1:0] i_cfg_idx;
    logic [RegW-1:0] i_cfg_data;

    mcsfs_in_if  in_ch ();
    mcsfs_out_if out_ch ();

    int errors, pending, frames, files;
    int tx_idle, rx_idle;
    int hold_reqs, hold_seen, hold_left;
    int cycles, n_bytes;

    logic [7:0] file_q[$];
    logic [7:0] body_q[$];

    mng_chunk_stream_frame_splitter_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    mcsfs_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_frames   (frames),
        .o_files    (files)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // The receiver honors a long hold-off whenever one is requested.
    always @(negedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic body_add(input logic [7:0] b);
        body_q.insert(body_q.size(), b);
    endtask

    task automatic file_add(input logic [7:0] b);
        file_q.insert(file_q.size(), b);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < tx_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= l;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_file();
        foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    // Leaves the input idle until every expected result has arrived, then for a settle period.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic put_u32(input logic [31:0] v);
        for (int k = 3; k >= 0; k--) file_add(v[8 * k +: 8]);
    endtask

    task automatic put_chunk(input logic [31:0] typ);
        put_u32(body_q.size());
        put_u32(typ);
        foreach (body_q[i]) file_add(body_q[i]);
        put_u32($urandom);
        body_q = {};
    endtask

    function automatic logic [31:0] pick_u32();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(1, 5000);
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_random(input int n);
        repeat (n) body_add(8'($urandom_range(255)));
    endtask

    task automatic add_fram();
        logic [31:0] d;
        d = pick_u32();
        body_add(8'($urandom_range(255)));
        repeat ($urandom_range(3)) body_add(8'($urandom_range(1, 255)));
        body_add(8'd0);
        body_add(($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
        fill_random(3);
        for (int k = 3; k >= 0; k--) body_add(d[8 * k +: 8]);
        if ($urandom_range(6) == 0) repeat ($urandom_range(1, body_q.size())) void'(body_q.pop_back());
        else if ($urandom_range(6) == 0) fill_random($urandom_range(1, 2));
        put_chunk(T_FRAM);
    endtask

    task automatic make_file();
        logic [31:0] pool[4];
        file_q = {};
        put_u32(MngSig[63:32]);
        put_u32(MngSig[31:0]);
        if ($urandom_range(24) == 0) file_q[$urandom_range(7)] = 8'($urandom_range(255));
        if ($urandom_range(4) != 0) begin
            if ($urandom_range(9) == 0) begin
                fill_random($urandom_range(27));
            end else begin
                for (int k = 0; k < 3; k++) begin
                    logic [31:0] v;
                    v = (k == 2) ? pick_u32() : $urandom;
                    for (int j = 3; j >= 0; j--) body_add(v[8 * j +: 8]);
                end
                fill_random(16);
            end
            put_chunk(T_MHDR);
        end
        repeat ($urandom_range(2)) begin
            if ($urandom_range(3) != 0) add_fram();
            fill_random($urandom_range(6));
            put_chunk(T_IHDR);
            if ($urandom_range(1)) begin
                fill_random($urandom_range(8));
                put_chunk(T_IDAT);
            end
            if ($urandom_range(19) != 0) put_chunk(T_IEND);
        end
        if ($urandom_range(9) == 0) begin
            pool = '{T_IHDR, T_IEND, T_FRAM, T_TERM};
            fill_random($urandom_range(4));
            put_chunk(($urandom_range(4) == 4) ? $urandom : pool[$urandom_range(3)]);
        end
        if ($urandom_range(11) == 0)
            repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
    endtask

    // With a pause, the first file goes out under a long receiver hold-off and
    // the sender then waits for every result.
    task automatic run_files(input int target, input bool_pause);
        int nf;
        nf = 0;
        while (n_bytes < target) begin
            if (nf == 0 && bool_pause) hold_reqs++;
            make_file();
            send_file();
            nf++;
            if (nf == 1 && bool_pause) drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_TICKS;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        out_ch.ready = 1'b0;
        tx_idle = 26;
        rx_idle = 46;
        hold_reqs = 0;
        hold_seen = 0;
        hold_left = 0;
        cycles = 0;
        n_bytes = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: one-byte file, broken signature, bare signature, 0xFF first byte, cut signature.
        send_byte(8'h8a, 1'b1);
        send_byte(8'h8a, 1'b0);
        send_byte(8'h00, 1'b1);
        for (int k = 0; k < 8; k++) send_byte(MngSig[63 - 8 * k -: 8], k == 7);
        send_byte(8'hFF, 1'b1);
        for (int k = 0; k < 5; k++) send_byte(MngSig[63 - 8 * k -: 8], k == 4);
        drain();

        write_reg(CFG_TICKS, 32'd1);
        write_reg(CFG_DELAY, 32'd0);
        run_files(120, 1'b1);

        drain();
        tx_idle = 46;
        rx_idle = 26;
        write_reg(CFG_TICKS, 32'hFFFF_FFFF);
        write_reg(CFG_DELAY, 32'hFFFF_FFFF);
        run_files(220, 1'b0);

        drain();
        tx_idle = 0;
        rx_idle = 0;
        write_reg(CFG_TICKS, $urandom_range(1, 100000));
        write_reg(CFG_DELAY, $urandom);
        run_files(320, 1'b1);

        drain();
        $display("Sent %0d file bytes; saw %0d frame ends and %0d status beats.",
                 n_bytes, frames, files);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/mcsfs_pkg.sv
rtl/mcsfs_if.sv
rtl/mcsfs_parser.sv
rtl/mcsfs_fifo.sv
rtl/mcsfs_emitter.sv
rtl/mng_chunk_stream_frame_splitter_core.sv
test/mcsfs_checker.sv
test/tb.sv
